### src/dais_pkg.sv
// Shared types, register indexes, mode codes and state encoding for the interlock sequencer.
package dais_pkg;

    localparam int DUR_W       = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int MODE_W      = 4;

    typedef struct packed {
        logic single_button_level;
        logic grabber_button_level;
    } dais_in_t;

    typedef struct packed {
        logic              single_extend;
        logic              outer_extend;
        logic              inner_extend;
        logic [MODE_W-1:0] mode_code;
    } dais_out_t;

    typedef struct packed {
        logic [DUR_W-1:0] first_stage_ticks;
        logic [DUR_W-1:0] second_stage_ticks;
        logic [DUR_W-1:0] grabber_retract_ticks;
        logic [DUR_W-1:0] single_retract_ticks;
    } dais_cfg_t;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_STAGE     = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_STAGE    = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_GRABBER_RETRACT = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_SINGLE_RETRACT  = CFG_INDEX_W'(3);

    // Register reset values
    localparam logic [DUR_W-1:0] FIRST_STAGE_RESET     = DUR_W'(250);
    localparam logic [DUR_W-1:0] SECOND_STAGE_RESET    = DUR_W'(250);
    localparam logic [DUR_W-1:0] GRABBER_RETRACT_RESET = DUR_W'(300);
    localparam logic [DUR_W-1:0] SINGLE_RETRACT_RESET  = DUR_W'(500);

    // Dense mode codes reported on the result
    localparam logic [MODE_W-1:0] MODE_WAIT         = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_S_DEPLOYED   = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_S_RETRACTING = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_S_RETRACTED  = MODE_W'(3);
    localparam logic [MODE_W-1:0] MODE_G_FIRST      = MODE_W'(4);
    localparam logic [MODE_W-1:0] MODE_G_SECOND     = MODE_W'(5);
    localparam logic [MODE_W-1:0] MODE_G_DEPLOYED   = MODE_W'(6);
    localparam logic [MODE_W-1:0] MODE_G_RETRACTING = MODE_W'(7);
    localparam logic [MODE_W-1:0] MODE_G_RETRACTED  = MODE_W'(8);

    typedef enum logic [8:0] {
        ST_WAIT         = 9'b000000001,
        ST_S_DEPLOYED   = 9'b000000010,
        ST_S_RETRACTING = 9'b000000100,
        ST_S_RETRACTED  = 9'b000001000,
        ST_G_FIRST      = 9'b000010000,
        ST_G_SECOND     = 9'b000100000,
        ST_G_DEPLOYED   = 9'b001000000,
        ST_G_RETRACTING = 9'b010000000,
        ST_G_RETRACTED  = 9'b100000000
    } dais_state_t;

    function automatic logic [MODE_W-1:0] mode_of(input dais_state_t st);
        logic [MODE_W-1:0] m;
        case (st)
            ST_WAIT:         m = MODE_WAIT;
            ST_S_DEPLOYED:   m = MODE_S_DEPLOYED;
            ST_S_RETRACTING: m = MODE_S_RETRACTING;
            ST_S_RETRACTED:  m = MODE_S_RETRACTED;
            ST_G_FIRST:      m = MODE_G_FIRST;
            ST_G_SECOND:     m = MODE_G_SECOND;
            ST_G_DEPLOYED:   m = MODE_G_DEPLOYED;
            ST_G_RETRACTING: m = MODE_G_RETRACTING;
            ST_G_RETRACTED:  m = MODE_G_RETRACTED;
            default:         m = MODE_S_RETRACTING;
        endcase
        return m;
    endfunction

endpackage

### src/dais_cfg.sv
// Duration register file written through the configuration port.
module dais_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dais_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dais_pkg::DUR_W-1:0]          cfg_data,
    output dais_pkg::dais_cfg_t                 cfg
);

    dais_pkg::dais_cfg_t cfg_reg;
    dais_pkg::dais_cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                dais_pkg::REG_FIRST_STAGE:     cfg_next.first_stage_ticks     = cfg_data;
                dais_pkg::REG_SECOND_STAGE:    cfg_next.second_stage_ticks    = cfg_data;
                dais_pkg::REG_GRABBER_RETRACT: cfg_next.grabber_retract_ticks = cfg_data;
                dais_pkg::REG_SINGLE_RETRACT:  cfg_next.single_retract_ticks  = cfg_data;
                default:                       cfg_next = cfg_reg; // drop unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_stage_ticks     <= dais_pkg::FIRST_STAGE_RESET;
            cfg_reg.second_stage_ticks    <= dais_pkg::SECOND_STAGE_RESET;
            cfg_reg.grabber_retract_ticks <= dais_pkg::GRABBER_RETRACT_RESET;
            cfg_reg.single_retract_ticks  <= dais_pkg::SINGLE_RETRACT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/dais_core.sv
// Request edge detection, interlock state machine and saturating tick timer.
module dais_core #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  dais_pkg::dais_in_t     item,
    input  dais_pkg::dais_cfg_t    cfg,
    output dais_pkg::dais_out_t    result
);

    localparam int CMP_W = (TIMER_WIDTH > dais_pkg::DUR_W) ? TIMER_WIDTH : dais_pkg::DUR_W;

    dais_pkg::dais_state_t   state_reg, state_next;
    logic                    s_sticky_reg, s_sticky_next;
    logic                    g_sticky_reg, g_sticky_next;
    logic                    s_prev_reg, g_prev_reg;
    logic [TIMER_WIDTH-1:0]  elapsed_reg, elapsed_next;

    logic s_tog, g_tog;
    logic restart;
    logic single_out, outer_out, inner_out;
    logic first_done, second_done, g_ret_done, s_ret_done;

    // Toggle sticky requests on rising edges before the state machine looks at them
    assign s_tog = s_sticky_reg ^ (~s_prev_reg & item.single_button_level);
    assign g_tog = g_sticky_reg ^ (~g_prev_reg & item.grabber_button_level);

    assign first_done  = CMP_W'(elapsed_reg) >= CMP_W'(cfg.first_stage_ticks);
    assign second_done = CMP_W'(elapsed_reg) >= CMP_W'(cfg.second_stage_ticks);
    assign g_ret_done  = CMP_W'(elapsed_reg) >= CMP_W'(cfg.grabber_retract_ticks);
    assign s_ret_done  = CMP_W'(elapsed_reg) >= CMP_W'(cfg.single_retract_ticks);

    always_comb
    begin
        state_next    = state_reg;
        s_sticky_next = s_tog;
        g_sticky_next = g_tog;
        restart       = 1'b0;
        single_out    = 1'b0;
        outer_out     = 1'b0;
        inner_out     = 1'b0;
        case (state_reg)
            dais_pkg::ST_WAIT, dais_pkg::ST_S_RETRACTED, dais_pkg::ST_G_RETRACTED:
            begin
                if (s_tog && !g_tog)
                begin
                    single_out = 1'b1;
                    state_next = dais_pkg::ST_S_DEPLOYED;
                end
                else if (!s_tog && g_tog)
                begin
                    outer_out  = 1'b1;
                    restart    = 1'b1;
                    state_next = dais_pkg::ST_G_FIRST;
                end
                else
                begin
                    state_next = dais_pkg::ST_WAIT;
                end
            end
            dais_pkg::ST_S_DEPLOYED:
            begin
                if (!s_tog || g_tog)
                begin
                    s_sticky_next = 1'b0;
                    restart       = 1'b1;
                    state_next    = dais_pkg::ST_S_RETRACTING;
                end
                else
                begin
                    single_out = 1'b1;
                end
            end
            dais_pkg::ST_S_RETRACTING:
            begin
                if (s_ret_done)
                begin
                    state_next = dais_pkg::ST_S_RETRACTED;
                end
            end
            dais_pkg::ST_G_FIRST, dais_pkg::ST_G_SECOND, dais_pkg::ST_G_DEPLOYED:
            begin
                if (s_tog || !g_tog)
                begin
                    // retract wins over stage advance
                    g_sticky_next = 1'b0;
                    restart       = 1'b1;
                    state_next    = dais_pkg::ST_G_RETRACTING;
                end
                else if (state_reg == dais_pkg::ST_G_FIRST)
                begin
                    outer_out = 1'b1;
                    if (first_done)
                    begin
                        restart    = 1'b1;
                        state_next = dais_pkg::ST_G_SECOND;
                    end
                end
                else if (state_reg == dais_pkg::ST_G_SECOND)
                begin
                    outer_out = 1'b1;
                    inner_out = 1'b1;
                    if (second_done)
                    begin
                        restart    = 1'b1;
                        state_next = dais_pkg::ST_G_DEPLOYED;
                    end
                end
                else
                begin
                    inner_out = 1'b1;
                end
            end
            dais_pkg::ST_G_RETRACTING:
            begin
                if (g_ret_done)
                begin
                    state_next = dais_pkg::ST_G_RETRACTED;
                end
            end
            default:
            begin
                state_next = dais_pkg::ST_S_RETRACTING;
            end
        endcase
    end

    // Restart or count up, holding at full scale
    always_comb
    begin
        if (restart)
        begin
            elapsed_next = '0;
        end
        else if (elapsed_reg != '1)
        begin
            elapsed_next = elapsed_reg + TIMER_WIDTH'(1);
        end
        else
        begin
            elapsed_next = elapsed_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dais_pkg::ST_WAIT;
            s_sticky_reg <= 1'b0;
            g_sticky_reg <= 1'b0;
            s_prev_reg   <= 1'b0;
            g_prev_reg   <= 1'b0;
            elapsed_reg  <= '0;
        end
        else if (step)
        begin
            state_reg    <= state_next;
            s_sticky_reg <= s_sticky_next;
            g_sticky_reg <= g_sticky_next;
            s_prev_reg   <= item.single_button_level;
            g_prev_reg   <= item.grabber_button_level;
            elapsed_reg  <= elapsed_next;
        end
    end

    assign result.single_extend = single_out;
    assign result.outer_extend  = outer_out;
    assign result.inner_extend  = inner_out;
    assign result.mode_code     = dais_pkg::mode_of(state_next);

    a_drive_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> !(single_out && (outer_out || inner_out)))
        else $error("single and grabber drives active together");

    a_single_retract_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (step && state_reg == dais_pkg::ST_S_DEPLOYED
              && state_next == dais_pkg::ST_S_RETRACTING)
        |=> (elapsed_reg == '0 && !s_sticky_reg))
        else $error("single retract did not restart timer or clear request");

    a_grabber_retract_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (step && state_next == dais_pkg::ST_G_RETRACTING
              && state_reg != dais_pkg::ST_G_RETRACTING)
        |=> (elapsed_reg == '0 && !g_sticky_reg))
        else $error("grabber retract did not restart timer or clear request");

endmodule

### src/dual_actuator_interlock_sequencer_top.sv
// Top level of the dual actuator interlock sequencer: handshakes, input and result registers.
//
// Each input transaction is one time tick carrying the raw levels of the two request
// buttons; each tick yields exactly one result transaction with the three cylinder
// drives and the new mode code. A rising button edge toggles that actuator's sticky
// request; the interlock then deploys the single cylinder, or the grabber in two timed
// stages (outer alone, then outer and inner, then inner held), and every retract runs a
// timed lockout. Durations come from four 16-bit registers in tick units and are
// measured by a TIMER_WIDTH-bit saturating counter; a duration beyond the counter range
// never expires. Throughput is one tick per clock while the output side is not stalled: a
// tick waits in the input register, the state update and timer compare are combinational,
// and the result register then presents the transaction. An empty input register takes a
// new tick while a finished result waits. Write the registers only while idle.
module dual_actuator_interlock_sequencer_top #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  dais_pkg::dais_in_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output dais_pkg::dais_out_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dais_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dais_pkg::DUR_W-1:0]          cfg_data
);

    dais_pkg::dais_cfg_t  cfg;
    dais_pkg::dais_in_t   in_item_reg;
    logic                 in_full_reg, in_full_next;
    dais_pkg::dais_out_t  out_item_reg;
    dais_pkg::dais_out_t  result;
    logic                 out_valid_reg, out_valid_next;
    logic                 advance;
    logic                 step;
    logic                 in_take;

    // Result stage can load when empty or when its transaction leaves this cycle
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_full_reg && advance;
    assign in_stall = in_full_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    dais_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dais_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Hold the input stage full until the core consumes it
    assign in_full_next   = in_take || (in_full_reg && !advance);
    // Hold the result while stalled; drop it once taken and nothing replaces it
    assign out_valid_next = step || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_data;
        end
        if (step)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    a_step_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid)
        else $error("consumed tick produced no result transaction");

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_full_reg |-> !in_stall)
        else $error("input stalled with an empty input stage");

    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.single_extend
                        && (out_data.outer_extend || out_data.inner_extend)))
        else $error("result drives both actuators");

endmodule

### verif/dual_actuator_interlock_sequencer_top_tb.sv
// Self-checking testbench for the dual actuator interlock sequencer top level.
module dual_actuator_interlock_sequencer_top_tb;

    localparam int DUR_W       = dais_pkg::DUR_W;
    localparam int CFG_INDEX_W = dais_pkg::CFG_INDEX_W;
    localparam int MODE_W      = dais_pkg::MODE_W;

    localparam int TIMER_W     = 16;
    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 7;
    // Longest stretch with no transaction on any channel before the run is abandoned.
    // The deliberate receiver hold-off is far shorter than this.
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_OFF    = 300;
    // Settling margin after the last expected result has been checked
    localparam int SETTLE      = 4;
    localparam int STEER_LIMIT = 60;

    // Indexes outside the register map; writes to them must leave every duration alone
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LOW  = CFG_INDEX_W'(4);
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HIGH = '1;

    // Directed button levels, first tick in the top pair: {single, grabber}.
    // Walks single deploy and retract, the two grabber stages, retract precedence
    // from either side, and simultaneous presses.
    localparam int DIRECTED_N = 22;
    localparam logic [2*DIRECTED_N-1:0] DIRECTED_LEVELS = {
        2'b00, 2'b10, 2'b10, 2'b00, 2'b10, 2'b00, 2'b01, 2'b01,
        2'b00, 2'b00, 2'b10, 2'b00, 2'b00, 2'b01, 2'b00, 2'b00,
        2'b11, 2'b00, 2'b11, 2'b00, 2'b01, 2'b00
    };

    // Tracks the interlock tick by tick and holds the drives each accepted tick must yield.
    class interlock_checker;
        dais_pkg::dais_cfg_t durations;
        logic [MODE_W-1:0]   mode;
        logic                single_sticky;
        logic                grabber_sticky;
        logic                single_prev;
        logic                grabber_prev;
        logic [TIMER_W-1:0]  elapsed;
        dais_pkg::dais_out_t expected_drives[$];
        int                  error_count;

        function new();
            durations.first_stage_ticks     = dais_pkg::FIRST_STAGE_RESET;
            durations.second_stage_ticks    = dais_pkg::SECOND_STAGE_RESET;
            durations.grabber_retract_ticks = dais_pkg::GRABBER_RETRACT_RESET;
            durations.single_retract_ticks  = dais_pkg::SINGLE_RETRACT_RESET;
            mode           = dais_pkg::MODE_WAIT;
            single_sticky  = 1'b0;
            grabber_sticky = 1'b0;
            single_prev    = 1'b0;
            grabber_prev   = 1'b0;
            elapsed        = '0;
            error_count    = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [DUR_W-1:0] value);
            case (index)
                dais_pkg::REG_FIRST_STAGE:     durations.first_stage_ticks     = value;
                dais_pkg::REG_SECOND_STAGE:    durations.second_stage_ticks    = value;
                dais_pkg::REG_GRABBER_RETRACT: durations.grabber_retract_ticks = value;
                dais_pkg::REG_SINGLE_RETRACT:  durations.single_retract_ticks  = value;
                default: ;
            endcase
        endfunction

        function bit duration_done(logic [DUR_W-1:0] dur);
            return 32'(elapsed) >= 32'(dur);
        endfunction

        function dais_pkg::dais_out_t predict_drives(dais_pkg::dais_in_t tick);
            dais_pkg::dais_out_t r;
            logic [MODE_W-1:0]   nxt;
            bit                  restart;
            r       = '0;
            restart = 1'b0;
            if (!single_prev && tick.single_button_level)
                single_sticky = ~single_sticky;
            if (!grabber_prev && tick.grabber_button_level)
                grabber_sticky = ~grabber_sticky;
            single_prev  = tick.single_button_level;
            grabber_prev = tick.grabber_button_level;

            nxt = mode;
            case (mode)
                dais_pkg::MODE_WAIT, dais_pkg::MODE_S_RETRACTED, dais_pkg::MODE_G_RETRACTED:
                begin
                    if (single_sticky && !grabber_sticky)
                    begin
                        r.single_extend = 1'b1;
                        nxt = dais_pkg::MODE_S_DEPLOYED;
                    end
                    else if (!single_sticky && grabber_sticky)
                    begin
                        r.outer_extend = 1'b1;
                        nxt = dais_pkg::MODE_G_FIRST;
                        restart = 1'b1;
                    end
                    else
                        nxt = dais_pkg::MODE_WAIT;
                end
                dais_pkg::MODE_S_DEPLOYED:
                begin
                    r.single_extend = 1'b1;
                    if (!single_sticky || grabber_sticky)
                    begin
                        r.single_extend = 1'b0;
                        single_sticky = 1'b0;
                        restart = 1'b1;
                        nxt = dais_pkg::MODE_S_RETRACTING;
                    end
                end
                dais_pkg::MODE_S_RETRACTING:
                begin
                    if (duration_done(durations.single_retract_ticks))
                        nxt = dais_pkg::MODE_S_RETRACTED;
                end
                dais_pkg::MODE_G_FIRST, dais_pkg::MODE_G_SECOND, dais_pkg::MODE_G_DEPLOYED:
                begin
                    if (mode == dais_pkg::MODE_G_FIRST)
                    begin
                        r.outer_extend = 1'b1;
                        if (duration_done(durations.first_stage_ticks))
                        begin
                            restart = 1'b1;
                            nxt = dais_pkg::MODE_G_SECOND;
                        end
                    end
                    else if (mode == dais_pkg::MODE_G_SECOND)
                    begin
                        r.outer_extend = 1'b1;
                        r.inner_extend = 1'b1;
                        if (duration_done(durations.second_stage_ticks))
                        begin
                            restart = 1'b1;
                            nxt = dais_pkg::MODE_G_DEPLOYED;
                        end
                    end
                    else
                        r.inner_extend = 1'b1;
                    // A retract request wins over a stage advance
                    if (single_sticky || !grabber_sticky)
                    begin
                        r.outer_extend = 1'b0;
                        r.inner_extend = 1'b0;
                        grabber_sticky = 1'b0;
                        restart = 1'b1;
                        nxt = dais_pkg::MODE_G_RETRACTING;
                    end
                end
                dais_pkg::MODE_G_RETRACTING:
                begin
                    if (duration_done(durations.grabber_retract_ticks))
                        nxt = dais_pkg::MODE_G_RETRACTED;
                end
                default: nxt = dais_pkg::MODE_S_RETRACTING;
            endcase

            if (restart)
                elapsed = '0;
            else if (elapsed != '1)
                elapsed = elapsed + TIMER_W'(1);
            mode = nxt;
            r.mode_code = nxt;
            return r;
        endfunction

        function void note_tick(dais_pkg::dais_in_t tick);
            expected_drives.push_back(predict_drives(tick));
        endfunction

        function void compare_field(string name, logic [MODE_W-1:0] want,
                                    logic [MODE_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                error_count++;
            end
        endfunction

        function void check_result(dais_pkg::dais_out_t got);
            dais_pkg::dais_out_t want;
            if (expected_drives.size() == 0)
            begin
                $error("result transaction with no tick outstanding: mode_code %0d",
                       got.mode_code);
                error_count++;
                return;
            end
            want = expected_drives.pop_front();
            compare_field("single_extend", MODE_W'(want.single_extend),
                          MODE_W'(got.single_extend));
            compare_field("outer_extend", MODE_W'(want.outer_extend),
                          MODE_W'(got.outer_extend));
            compare_field("inner_extend", MODE_W'(want.inner_extend),
                          MODE_W'(got.inner_extend));
            compare_field("mode_code", want.mode_code, got.mode_code);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    dais_pkg::dais_in_t     in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    dais_pkg::dais_out_t    out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DUR_W-1:0]       cfg_data  = '0;

    // Sender idle odds are read by the driving process only; the receiver odds and the
    // hold-off request count cross processes, so update those with nonblocking writes.
    int send_idle_pct     = 0;
    int stall_pct         = 0;
    int hold_off_requests = 0;
    int quiet_cycles      = 0;

    // Current button levels of the random stream
    logic single_level  = 1'b0;
    logic grabber_level = 1'b0;

    interlock_checker chk = new();

    dual_actuator_interlock_sequencer_top #(
        .TIMER_WIDTH(TIMER_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // Receiver: stall at random, or hold off for a long counted stretch on request.
    initial
    begin
        int hold_left;
        int served;
        hold_left = 0;
        served    = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && served != hold_off_requests)
            begin
                hold_left = HOLD_OFF;
                served++;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Check every result transaction against the oldest outstanding prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            chk.check_result(out_data);
    end

    // Abort when no transaction of any kind has moved for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("dual_actuator_interlock_sequencer_top regression: fail");
            $finish;
        end
    end

    // Offer one tick, idling first at the sender's odds, and hold it until taken.
    task automatic drive_tick(input dais_pkg::dais_in_t tick);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= tick;
        do
            @(posedge clk);
        while (in_stall);
        chk.note_tick(tick);
    endtask

    // Mostly hold the levels so presses last several ticks; flip one button now and
    // then, and occasionally throw both levels at random.
    function automatic dais_pkg::dais_in_t next_buttons();
        dais_pkg::dais_in_t t;
        int unsigned        pick;
        pick = $urandom_range(99);
        if (pick < 7)
            single_level = ~single_level;
        else if (pick < 15)
            grabber_level = ~grabber_level;
        else if (pick < 19)
        begin
            single_level  = 1'($urandom_range(1));
            grabber_level = 1'($urandom_range(1));
        end
        t.single_button_level  = single_level;
        t.grabber_button_level = grabber_level;
        return t;
    endfunction

    task automatic random_ticks(input int count);
        repeat (count) drive_tick(next_buttons());
    endtask

    // Stop offering and wait until every predicted result has been checked.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (chk.expected_drives.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Leave cfg_valid high; the caller drops it once its run of writes is done.
    task automatic write_duration(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [DUR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        chk.write_reg(index, value);
    endtask

    task automatic set_durations(input logic [DUR_W-1:0] first_stage,
                                 input logic [DUR_W-1:0] second_stage,
                                 input logic [DUR_W-1:0] grabber_retract,
                                 input logic [DUR_W-1:0] single_retract);
        write_duration(dais_pkg::REG_FIRST_STAGE, first_stage);
        write_duration(dais_pkg::REG_SECOND_STAGE, second_stage);
        write_duration(dais_pkg::REG_GRABBER_RETRACT, grabber_retract);
        write_duration(dais_pkg::REG_SINGLE_RETRACT, single_retract);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_durations(input int unsigned max_ticks);
        set_durations(DUR_W'($urandom_range(max_ticks)), DUR_W'($urandom_range(max_ticks)),
                      DUR_W'($urandom_range(max_ticks)), DUR_W'($urandom_range(max_ticks)));
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct    <= recv_pct;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset durations, nothing written yet; run flat out.
        set_idle(0, 0);
        random_ticks(40);
        drain_results();

        // Zero durations: every stage and lockout ends on its first tick. Hit the
        // unmapped indexes with all-ones and all-zero data first; they must be ignored.
        write_duration(REG_UNUSED_LOW, '1);
        write_duration(REG_UNUSED_HIGH, '0);
        set_durations('0, '0, '0, '0);
        for (int i = 0; i < DIRECTED_N; i++)
            drive_tick(dais_pkg::dais_in_t'(DIRECTED_LEVELS[2*(DIRECTED_N-1-i) +: 2]));
        random_ticks(60);
        drain_results();

        // Short durations with a bursty sender.
        random_durations(6);
        set_idle(78, 0);
        random_ticks(110);
        drain_results();

        // Hold off the receiver while the sender keeps offering, so the block fills
        // and stalls its input; then pause the sender until everything is back.
        random_durations(12);
        set_idle(0, 0);
        hold_off_requests <= hold_off_requests + 1;
        random_ticks(50);
        drain_results();
        set_idle(0, 78);
        random_ticks(90);
        drain_results();

        // Full-scale stage timers: the grabber sits in its first stage until a retract.
        set_durations('1, '1, DUR_W'($urandom_range(4)), DUR_W'($urandom_range(4)));
        set_idle(31, 31);
        random_ticks(80);
        drain_results();

        random_durations(8);
        random_ticks(100);
        drain_results();

        // Full-scale single lockout: steer into it, then confirm it holds.
        set_durations('0, '0, '0, '1);
        set_idle(0, 0);
        for (int n = 0; n < STEER_LIMIT && chk.mode != dais_pkg::MODE_S_RETRACTING; n++)
            drive_tick(next_buttons());
        random_ticks(20);
        drain_results();

        if (chk.error_count == 0)
            $display("dual_actuator_interlock_sequencer_top regression: pass");
        else
            $display("dual_actuator_interlock_sequencer_top regression: fail");
        $finish;
    end

endmodule
